@@ rtl/core/fcull_pkg.sv @@
package fcull_pkg;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_BOX    = 2'd1;
  localparam logic [1:0] FUNC_SPHERE = 2'd2;

  localparam logic [3:0] LAST_ELEM = 4'd15;

  localparam int RING_DEPTH = 24;
  localparam int MAT_DEPTH  = 16;

  // 35 root bits, 50 quotient bits, 6 planes of 8 terms
  localparam logic [5:0] ROOT_LAST  = 6'd34;
  localparam logic [5:0] DIV_LAST   = 6'd49;
  localparam logic [5:0] TEST_LAST  = 6'd47;
  localparam logic [2:0] PLANE_LAST = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XTR,
    ST_TST,
    ST_FIN
  } top_state_t;

  typedef enum logic [2:0] {
    XS_IDLE,
    XS_RAW,
    XS_SQ,
    XS_ROOT,
    XS_PREP,
    XS_DIV,
    XS_PUSH
  } xs_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } xt_stat_t;

  typedef struct packed {
    logic done;
    logic visible;
  } ts_stat_t;

endpackage

@@ rtl/core/fcull_if.sv @@
interface fcull_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [3:0]         elem_index;
  logic signed [31:0] elem_value;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        half_x;
  logic [30:0]        half_y;
  logic [30:0]        half_z;
  logic [30:0]        radius;

  modport source (
    output valid, func, elem_index, elem_value, center_x, center_y, center_z,
           half_x, half_y, half_z, radius,
    input  ready
  );
  modport sink (
    input  valid, func, elem_index, elem_value, center_x, center_y, center_z,
           half_x, half_y, half_z, radius,
    output ready
  );
endinterface

interface fcull_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

@@ rtl/core/fcull_cell.sv @@
module fcull_cell #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  logic signed [W-1:0] d,
  output logic signed [W-1:0] q
);

  logic signed [W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

@@ rtl/core/fcull_extract.sv @@
module fcull_extract #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld_en,
  input  logic [3:0]           ld_idx,
  input  logic signed [31:0]   ld_val,
  input  logic                 start,
  output fcull_pkg::xt_stat_t  st,
  output logic                 push,
  output logic signed [CW-1:0] push_val
);

  localparam int VW = 52;
  localparam logic signed [VW-1:0] SAT_HI = VW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

  fcull_pkg::xs_state_t state_r, state_nxt;

  logic signed [31:0] mat_r [fcull_pkg::MAT_DEPTH];
  logic [2:0]         plane_r;
  logic [1:0]         comp_r;
  logic [5:0]         cnt_r;
  logic signed [32:0] raw_r [4];
  logic signed [32:0] raw_c [4];
  logic [65:0]        sq_r;
  logic [67:0]        sum_r;
  logic [69:0]        rad_r;
  logic [37:0]        rem_r;
  logic [34:0]        root_r;
  logic [49:0]        dvd_r;
  logic [35:0]        drem_r;
  logic [49:0]        quo_r;

  logic [1:0]         kx;
  logic [32:0]        sq_mag;
  logic [32:0]        div_mag;
  logic [37:0]        rem_sh;
  logic [37:0]        trial;
  logic               root_ge;
  logic [36:0]        dr_sh;
  logic               div_ge;
  logic signed [VW-1:0] val_full;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  // plane row picks which matrix row joins the fourth row
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [32:0] w;
      logic signed [32:0] e;
      w = 33'(mat_r[k*4+3]);
      case (plane_r[2:1])
        2'd0:    e = 33'(mat_r[k*4]);
        2'd1:    e = 33'(mat_r[k*4+1]);
        default: e = 33'(mat_r[k*4+2]);
      endcase
      raw_c[k] = plane_r[0] ? (w - e) : (w + e);
    end
  end

  // component order d, nx, ny, nz so the ring holds d first
  assign kx      = (comp_r == 2'd0) ? 2'd3 : comp_r - 2'd1;
  assign sq_mag  = mag33(raw_r[cnt_r[1:0]]);
  assign div_mag = mag33(raw_r[kx]);

  assign rem_sh  = {rem_r[35:0], rad_r[69:68]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign root_ge = rem_sh >= trial;

  assign dr_sh   = {drem_r, dvd_r[49]};
  assign div_ge  = dr_sh >= {2'b00, root_r};

  always_comb begin
    if (root_r == '0) begin
      val_full = VW'(raw_r[kx]);
    end else if (raw_r[kx][32]) begin
      val_full = -$signed({2'b00, quo_r});
    end else begin
      val_full = $signed({2'b00, quo_r});
    end
    if (val_full > SAT_HI) begin
      push_val = SAT_HI[CW-1:0];
    end else if (val_full < SAT_LO) begin
      push_val = SAT_LO[CW-1:0];
    end else begin
      push_val = val_full[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcull_pkg::XS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    st.busy   = state_r != fcull_pkg::XS_IDLE;
    st.done   = 1'b0;
    unique case (state_r)
      fcull_pkg::XS_IDLE: begin
        if (start) state_nxt = fcull_pkg::XS_RAW;
      end
      fcull_pkg::XS_RAW:  state_nxt = fcull_pkg::XS_SQ;
      fcull_pkg::XS_SQ: begin
        if (cnt_r[1:0] == 2'd3) state_nxt = fcull_pkg::XS_ROOT;
      end
      fcull_pkg::XS_ROOT: begin
        if (cnt_r == fcull_pkg::ROOT_LAST) state_nxt = fcull_pkg::XS_PREP;
      end
      fcull_pkg::XS_PREP: begin
        state_nxt = (root_r == '0) ? fcull_pkg::XS_PUSH : fcull_pkg::XS_DIV;
      end
      fcull_pkg::XS_DIV: begin
        if (cnt_r == fcull_pkg::DIV_LAST) state_nxt = fcull_pkg::XS_PUSH;
      end
      fcull_pkg::XS_PUSH: begin
        push = 1'b1;
        if (comp_r == 2'd3) begin
          if (plane_r == fcull_pkg::PLANE_LAST) begin
            state_nxt = fcull_pkg::XS_IDLE;
            st.done   = 1'b1;
          end else begin
            state_nxt = fcull_pkg::XS_RAW;
          end
        end else begin
          state_nxt = fcull_pkg::XS_PREP;
        end
      end
      default: state_nxt = fcull_pkg::XS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fcull_pkg::MAT_DEPTH; i++) mat_r[i] <= '0;
    end else if (ld_en) begin
      mat_r[ld_idx] <= ld_val;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fcull_pkg::XS_IDLE: begin
        plane_r <= '0;
      end
      fcull_pkg::XS_RAW: begin
        for (int k = 0; k < 4; k++) raw_r[k] <= raw_c[k];
        cnt_r  <= '0;
        sum_r  <= '0;
        comp_r <= '0;
      end
      fcull_pkg::XS_SQ: begin
        sq_r <= 66'(sq_mag * sq_mag);
        if (cnt_r[1:0] != 2'd0) sum_r <= sum_r + 68'(sq_r);
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) begin
          rad_r  <= {2'b00, sum_r + 68'(sq_r)};
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end
      end
      fcull_pkg::XS_ROOT: begin
        rem_r  <= root_ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[33:0], root_ge};
        rad_r  <= {rad_r[67:0], 2'b00};
        cnt_r  <= cnt_r + 6'd1;
      end
      fcull_pkg::XS_PREP: begin
        // rounding half away from zero: add half the length
        dvd_r  <= {1'b0, div_mag, 16'b0} + {16'b0, root_r[34:1]};
        drem_r <= '0;
        quo_r  <= '0;
        cnt_r  <= '0;
      end
      fcull_pkg::XS_DIV: begin
        drem_r <= div_ge ? 36'(dr_sh - {2'b00, root_r}) : dr_sh[35:0];
        quo_r  <= {quo_r[48:0], div_ge};
        dvd_r  <= {dvd_r[48:0], 1'b0};
        cnt_r  <= cnt_r + 6'd1;
      end
      fcull_pkg::XS_PUSH: begin
        comp_r <= comp_r + 2'd1;
        if (comp_r == 2'd3) plane_r <= plane_r + 3'd1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/fcull_test.sv @@
module fcull_test #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 is_box,
  input  logic signed [31:0]   cx,
  input  logic signed [31:0]   cy,
  input  logic signed [31:0]   cz,
  input  logic [30:0]          hx,
  input  logic [30:0]          hy,
  input  logic [30:0]          hz,
  input  logic [30:0]          radius,
  input  logic signed [CW-1:0] head,
  output logic                 rot,
  output fcull_pkg::ts_stat_t  st
);

  localparam int TW = CW + 34;
  localparam int SW = ((TW > 64) ? TW : 64) + 1;
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  logic signed [31:0] c_r [3];
  logic [30:0]        h_r [3];
  logic [46:0]        ext_r;
  logic               run_r;
  logic [5:0]         step_r;
  logic signed [TW-1:0] prod_r;
  logic               pv_r;
  logic               first_r;
  logic               last_r;
  logic               fin_r;
  logic signed [63:0] acc_r;
  logic               culled_r;
  logic               done_r;

  logic [2:0]          s;
  logic [1:0]          ci;
  logic signed [CW:0]  op_a;
  logic signed [32:0]  op_b;
  logic signed [31:0]  c_sel;
  logic [30:0]         h_sel;
  logic signed [TW-1:0] term;
  logic signed [SW-1:0] sum_full;
  logic signed [63:0]  acc_nxt;

  // each plane: d, then n*c and |n|*h per axis, then the sphere radius
  assign s   = step_r[2:0];
  assign ci  = s[0] ? s[2:1] : s[2:1] - 2'd1;
  assign rot = run_r && !s[0];

  always_comb begin
    case (ci)
      2'd0:    begin c_sel = c_r[0]; h_sel = h_r[0]; end
      2'd1:    begin c_sel = c_r[1]; h_sel = h_r[1]; end
      default: begin c_sel = c_r[2]; h_sel = h_r[2]; end
    endcase
    if (s[0]) begin
      op_a = (CW+1)'(head);
      op_b = 33'(c_sel);
    end else begin
      op_a = head[CW-1] ? -(CW+1)'(head) : (CW+1)'(head);
      op_b = $signed({2'b00, h_sel});
    end
    if (s == 3'd0) begin
      term = TW'(head) <<< 16;
    end else if (s == 3'd7) begin
      term = $signed(TW'(ext_r));
    end else begin
      term = TW'(op_a * op_b);
    end
  end

  always_comb begin
    if (first_r) begin
      sum_full = SW'(prod_r);
    end else begin
      sum_full = SW'(acc_r) + SW'(prod_r);
    end
    if (sum_full > SW'(ACC_MAX)) begin
      acc_nxt = ACC_MAX;
    end else if (sum_full < SW'(ACC_MIN)) begin
      acc_nxt = ACC_MIN;
    end else begin
      acc_nxt = sum_full[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      c_r[0] <= cx;
      c_r[1] <= cy;
      c_r[2] <= cz;
      h_r[0] <= is_box ? hx : '0;
      h_r[1] <= is_box ? hy : '0;
      h_r[2] <= is_box ? hz : '0;
      ext_r  <= is_box ? '0 : {radius, 16'b0};
    end
    prod_r  <= term;
    first_r <= s == 3'd0;
    last_r  <= s == 3'd7;
    if (pv_r) acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      step_r   <= '0;
      pv_r     <= 1'b0;
      fin_r    <= 1'b0;
      done_r   <= 1'b0;
      culled_r <= 1'b0;
    end else begin
      pv_r   <= run_r;
      fin_r  <= run_r && step_r == fcull_pkg::TEST_LAST;
      done_r <= pv_r && fin_r;
      if (start) begin
        run_r    <= 1'b1;
        step_r   <= '0;
        culled_r <= 1'b0;
      end else if (run_r) begin
        step_r <= step_r + 6'd1;
        if (step_r == fcull_pkg::TEST_LAST) run_r <= 1'b0;
      end
      if (pv_r && last_r && acc_nxt[63]) culled_r <= 1'b1;
    end
  end

  assign st.done    = done_r;
  assign st.visible = !culled_r;

endmodule

@@ rtl/core/frustum_plane_box_sphere_cull_unit.sv @@
// Frustum culling unit. Load transactions write the 4x4 view-projection matrix
// (element = column*4 + row); writing element 15 extracts, normalizes and
// stores the six clip planes (per plane one 35-step square root and four
// 50-step divisions, the divisions skipped when the length is zero), and no
// transaction is taken meanwhile. The planes sit in a ring of 24 cells that
// rotates past a single multiply-accumulate; a box or sphere test walks 48
// terms through it one per cycle. A finished result waits in the output
// register while the next transaction is taken. Before the first matrix is
// complete every test reports visible.
module frustum_plane_box_sphere_cull_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  fcull_in_if.sink  in_ch,
  fcull_out_if.source out_ch
);

  localparam int CW = COORD_WIDTH;

  fcull_pkg::top_state_t state_r, state_nxt;
  fcull_pkg::xt_stat_t   xt_st;
  fcull_pkg::ts_stat_t   ts_st;

  logic in_acc;
  logic ld_en;
  logic xt_start;
  logic ts_start;
  logic slot_free;
  logic out_load;
  logic out_valid_r, out_valid_nxt;
  logic out_vis_r, out_vis_nxt;
  logic pend_r;

  logic                 push;
  logic signed [CW-1:0] push_val;
  logic                 rot;
  logic                 ring_shift;
  logic signed [CW-1:0] ring_q [fcull_pkg::RING_DEPTH];
  logic signed [CW-1:0] ring_tail;

  assign in_ch.ready = state_r == fcull_pkg::ST_IDLE;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ld_en       = in_acc && in_ch.func == fcull_pkg::FUNC_LOAD;
  assign xt_start    = ld_en && in_ch.elem_index == fcull_pkg::LAST_ELEM;
  assign ts_start    = in_acc && (in_ch.func == fcull_pkg::FUNC_BOX ||
                                  in_ch.func == fcull_pkg::FUNC_SPHERE);
  assign slot_free   = !out_valid_r || out_ch.ready;

  fcull_extract #(.CW(CW)) u_extract (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_en    (ld_en),
    .ld_idx   (in_ch.elem_index),
    .ld_val   (in_ch.elem_value),
    .start    (xt_start),
    .st       (xt_st),
    .push     (push),
    .push_val (push_val)
  );

  fcull_test #(.CW(CW)) u_test (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ts_start),
    .is_box (in_ch.func == fcull_pkg::FUNC_BOX),
    .cx     (in_ch.center_x),
    .cy     (in_ch.center_y),
    .cz     (in_ch.center_z),
    .hx     (in_ch.half_x),
    .hy     (in_ch.half_y),
    .hz     (in_ch.half_z),
    .radius (in_ch.radius),
    .head   (ring_q[0]),
    .rot    (rot),
    .st     (ts_st)
  );

  // new planes enter at the tail, a test rotates the head back to the tail
  assign ring_shift = push || rot;
  assign ring_tail  = push ? push_val : ring_q[0];

  for (genvar i = 0; i < fcull_pkg::RING_DEPTH; i++) begin : g_ring
    logic signed [CW-1:0] cell_d;
    if (i == fcull_pkg::RING_DEPTH - 1) begin : g_tail
      assign cell_d = ring_tail;
    end else begin : g_body
      assign cell_d = ring_q[i + 1];
    end
    fcull_cell #(.W(CW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ring_shift),
      .d     (cell_d),
      .q     (ring_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcull_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_vis_r <= out_vis_nxt;
    if (state_r == fcull_pkg::ST_TST && ts_st.done) pend_r <= ts_st.visible;
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      fcull_pkg::ST_IDLE: begin
        if (xt_start) begin
          state_nxt = fcull_pkg::ST_XTR;
        end else if (ts_start) begin
          state_nxt = fcull_pkg::ST_TST;
        end
      end
      fcull_pkg::ST_XTR: begin
        if (xt_st.done) state_nxt = fcull_pkg::ST_IDLE;
      end
      fcull_pkg::ST_TST: begin
        if (ts_st.done) begin
          if (slot_free) begin
            out_load  = 1'b1;
            state_nxt = fcull_pkg::ST_IDLE;
          end else begin
            state_nxt = fcull_pkg::ST_FIN;
          end
        end
      end
      fcull_pkg::ST_FIN: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = fcull_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcull_pkg::ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_vis_nxt   = (state_r == fcull_pkg::ST_FIN) ? pend_r : ts_st.visible;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
      out_vis_nxt   = out_vis_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.visible = out_vis_r;

`ifndef NO_ASSERTIONS
  a_ring_one_owner: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && rot))
    else $error("plane ring pushed and rotated together");

  a_test_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    ts_st.done |-> state_r == fcull_pkg::ST_TST)
    else $error("test finished outside test state");

  a_xtr_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    xt_st.done |-> state_r == fcull_pkg::ST_XTR)
    else $error("extraction finished outside extract state");

  a_xtr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fcull_pkg::ST_XTR && !xt_st.done |=> xt_st.busy)
    else $error("extraction idle while block waits on it");

  a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
    ts_start |=> state_r == fcull_pkg::ST_TST && !ts_st.done)
    else $error("accepted test did not start");
`endif

endmodule

@@ sim/fcull_checker.sv @@
`timescale 1ns / 100ps

module fcull_checker (
  input  logic  clk,
  input  logic  rst_n,
  fcull_in_if   in_ch,
  fcull_out_if  out_ch,
  output int    fail_count,
  output int    visible_pending
);

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  logic [31:0] matrix_q [16];
  longint      plane_q  [24];
  bit          visible_fifo [$];

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    return longint'(s[63:0]);
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // gribb-hartmann planes from the stored matrix, normalized by floor sqrt
  function automatic void derive_planes();
    longint            raw [4];
    longint unsigned   m, q, len, t;
    logic [127:0]      sumsq;
    longint            v;
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 4; k++) begin
        longint w, e;
        w = longint'($signed(matrix_q[k*4+3]));
        e = longint'($signed(matrix_q[k*4+(p>>1)]));
        raw[k] = (p & 1) ? w - e : w + e;
      end
      sumsq = '0;
      for (int k = 0; k < 3; k++) begin
        m = abs64(raw[k]);
        sumsq += {64'd0, m} * {64'd0, m};
      end
      len = 0;
      for (int b = 34; b >= 0; b--) begin
        t = len | (64'd1 << b);
        if ({64'd0, t} * {64'd0, t} <= sumsq) len = t;
      end
      for (int k = 0; k < 4; k++) begin
        v = raw[k];
        if (len > 0) begin
          m = abs64(raw[k]);
          q = ((m << 16) + (len >> 1)) / len;
          v = raw[k] < 0 ? -longint'(q) : longint'(q);
        end
        plane_q[p*4+k] = clamp_coord(v);
      end
    end
  endfunction

  function automatic bit volume_visible(longint c [3], longint unsigned h [3], longint extra);
    longint acc, n;
    for (int p = 0; p < 6; p++) begin
      acc = plane_q[p*4+3] * 65536;
      for (int k = 0; k < 3; k++) begin
        n = plane_q[p*4+k];
        acc = add_sat64(acc, n * c[k]);
        acc = add_sat64(acc, longint'(abs64(n) * h[k]));
      end
      acc = add_sat64(acc, extra);
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (matrix_q[i]) matrix_q[i] = '0;
      foreach (plane_q[i]) plane_q[i] = 0;
      visible_fifo.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (visible_fifo.size() == 0) begin
          $error("unexpected result transaction, visible=%0d", out_ch.visible);
          fail_count++;
        end else begin
          bit want;
          want = visible_fifo.pop_front();
          if (out_ch.visible !== want) begin
            $error("visible mismatch: expected %0d actual %0d", want, out_ch.visible);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        longint          c [3];
        longint unsigned h [3];
        c[0] = longint'(in_ch.center_x);
        c[1] = longint'(in_ch.center_y);
        c[2] = longint'(in_ch.center_z);
        h[0] = 0; h[1] = 0; h[2] = 0;
        case (in_ch.func)
          fcull_pkg::FUNC_LOAD: begin
            matrix_q[in_ch.elem_index] = in_ch.elem_value;
            if (in_ch.elem_index == fcull_pkg::LAST_ELEM) derive_planes();
          end
          fcull_pkg::FUNC_BOX: begin
            h[0] = in_ch.half_x; h[1] = in_ch.half_y; h[2] = in_ch.half_z;
            visible_fifo.insert(visible_fifo.size(), volume_visible(c, h, 0));
          end
          fcull_pkg::FUNC_SPHERE: begin
            visible_fifo.insert(visible_fifo.size(),
                                volume_visible(c, h, longint'(in_ch.radius) * 65536));
          end
          default: ;
        endcase
      end
    end
    visible_pending = visible_fifo.size();
  end
endmodule

@@ sim/tb_frustum_plane_box_sphere_cull_unit.sv @@
`timescale 1ns / 100ps

module tb_frustum_plane_box_sphere_cull_unit;

  localparam int  IDLE_LIMIT = 20000;
  localparam int  ONE        = 65536;
  localparam int  RAND_TESTS = 700;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [30:0] HALF_ONE    = 31'(ONE);
  localparam logic [30:0] HALF_HALF   = 31'(ONE / 2);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   visible_pending;
  int   idle_cycles = 0;
  int   results_seen = 0;
  bit   held_off = 1'b0;

  fcull_in_if  in_ch ();
  fcull_out_if out_ch ();

  frustum_plane_box_sphere_cull_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fcull_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .visible_pending (visible_pending)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(9) < 7) return $urandom_range(32 * ONE) - 16 * ONE;
    return $urandom;
  endfunction

  function automatic logic [30:0] pick_half();
    if ($urandom_range(9) < 7) return 31'($urandom_range(4 * ONE));
    return 31'($urandom);
  endfunction

  // unused fields carry random junk
  task automatic send_item(logic [1:0] f, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [30:0] hx, logic [30:0] hy, logic [30:0] hz,
                           logic [30:0] rad);
    in_ch.func       = f;
    in_ch.elem_index = idx;
    in_ch.elem_value = val;
    in_ch.center_x   = cx;
    in_ch.center_y   = cy;
    in_ch.center_z   = cz;
    in_ch.half_x     = hx;
    in_ch.half_y     = hy;
    in_ch.half_z     = hz;
    in_ch.radius     = rad;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    repeat (pick_gap()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_load(logic [3:0] idx, logic [31:0] val);
    send_item(fcull_pkg::FUNC_LOAD, idx, val, $urandom, $urandom, $urandom,
              31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
  endtask

  task automatic send_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
    send_item(fcull_pkg::FUNC_BOX, 4'($urandom), $urandom, cx, cy, cz, hx, hy, hz,
              31'($urandom));
  endtask

  task automatic send_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [30:0] rad);
    send_item(fcull_pkg::FUNC_SPHERE, 4'($urandom), $urandom, cx, cy, cz,
              31'($urandom), 31'($urandom), 31'($urandom), rad);
  endtask

  task automatic send_unused();
    send_item(FUNC_UNUSED, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
              31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
  endtask

  // full matrix in shuffled order, element 15 last to trigger extraction
  task automatic load_matrix(int style);
    int          order [15];
    logic [31:0] val;
    foreach (order[i]) order[i] = i;
    order.shuffle();
    for (int i = 0; i < 16; i++) begin
      case (style)
        0: val = $urandom_range(4 * ONE) - 2 * ONE;
        1: val = $urandom;
        default: val = ($urandom_range(9) == 0) ? $urandom_range(2 * ONE) - ONE : 0;
      endcase
      send_load(i == 15 ? fcull_pkg::LAST_ELEM : 4'(order[i]), val);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = fcull_pkg::FUNC_LOAD;
    in_ch.elem_index = '0;
    in_ch.elem_value = '0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.center_z = '0;
    in_ch.half_x = '0;
    in_ch.half_y = '0;
    in_ch.half_z = '0;
    in_ch.radius = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // all planes zero before any load
    send_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '1, '1, '1);
    send_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h0, '0);
    send_unused();
    // identity matrix gives the unit cube
    for (int i = 0; i < 16; i++) send_load(4'(i), (i % 5 == 0) ? ONE : 0);
    send_box(0, 0, 0, HALF_HALF, HALF_HALF, HALF_HALF);
    send_box(5 * ONE, 0, 0, HALF_ONE, HALF_ONE, HALF_ONE);
    send_box(-2 * ONE, ONE / 2, 0, HALF_ONE, '0, '0);
    send_sphere(3 * ONE, 0, 0, HALF_ONE);
    send_sphere(0, 2 * ONE, 0, HALF_ONE);
    send_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '1, '1, '1);
    send_sphere(32'h8000_0000, 0, 32'h7fff_ffff, '1);

    for (int n = 0; n < RAND_TESTS; n++) begin
      int r;
      if (n % 60 == 0) load_matrix($urandom_range(9) < 6 ? 0 : $urandom_range(2, 1));
      r = $urandom_range(99);
      if (r < 45)
        send_box(pick_coord(), pick_coord(), pick_coord(),
                 pick_half(), pick_half(), pick_half());
      else if (r < 90)
        send_sphere(pick_coord(), pick_coord(), pick_coord(), pick_half());
      else if (r < 95)
        send_load(4'($urandom_range(14)), $urandom);
      else
        send_unused();
    end

    in_ch.valid = 1'b0;
    while (visible_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // result side, with one long hold-off to back up the input
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 30) begin
        held_off = 1'b1;
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      if (out_ch.ready && $urandom_range(9) < 8) begin
        out_ch.ready = 1'b1;
      end else begin
        int g;
        g = pick_gap();
        out_ch.ready = (g == 0);
        if (g > 1) begin
          repeat (g - 1) @(negedge clk);
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end
endmodule
